// ===== hdl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the JSON string unescaper.
// No dependencies; every other file imports this package.
package jsu_pkg;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned FifoAddrW = $clog2(FifoDepth);
   localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_U       = 8'h75;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_FF    = 8'h0C;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_TAB   = 8'h09;

   typedef enum logic [1:0] {
      ST_DATA   = 2'd0,
      ST_DONE   = 2'd1,
      ST_DECODE = 2'd2,
      ST_CTRL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } dec_result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic rsp_item_type make_rsp(input logic [7:0] b, input status_type s,
                                              input logic l);
      rsp_item_type r;
      r.out_byte = b;
      r.status   = s;
      r.last     = l;
      return r;
   endfunction

endpackage

// ===== hdl/jsu_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Depends on jsu_pkg for the status type.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_start;

   modport source (output valid, in_byte, string_start, input ready);
   modport sink   (input valid, in_byte, string_start, output ready);
endinterface

interface jsu_rsp_if;
   import jsu_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   status_type status;
   logic       last;

   modport source (output valid, out_byte, status, last, input ready);
   modport sink   (input valid, out_byte, status, last, output ready);
endinterface

// ===== hdl/jsu_decode.sv =====
`timescale 1ns / 1ps
// Unescape state registers and the per-byte decode logic.
// Depends on jsu_pkg; produces up to two results per accepted byte.
module jsu_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [7:0]              in_byte,
   input  logic                    string_start,
   output jsu_pkg::dec_result_type dec
);
   import jsu_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [1:0]    hex_count_ff, hex_count_in;
   logic [11:0]   hex_accum_ff, hex_accum_in;
   hex_digit_type hd;
   logic [15:0]   code;

   always_comb begin
      hd   = hex_value(in_byte);
      code = {hex_accum_ff, hd.value};
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      dec.count    = 2'd0;
      dec.first    = make_rsp(8'h00, ST_DATA, 1'b1);
      dec.second   = make_rsp(8'h00, ST_DATA, 1'b1);
      if (string_start) begin
         mode_in      = MODE_STR;
         hex_count_in = 2'd0;
         hex_accum_in = 12'd0;
      end else if (mode_ff != MODE_IDLE) begin
         if (in_byte < CTRL_LIMIT) begin
            mode_in   = MODE_IDLE;
            dec.count = 2'd1;
            dec.first = make_rsp(8'h00, ST_CTRL, 1'b1);
         end else begin
            case (mode_ff)
               MODE_STR: begin
                  if (in_byte == CH_QUOTE) begin
                     mode_in   = MODE_IDLE;
                     dec.count = 2'd1;
                     dec.first = make_rsp(8'h00, ST_DONE, 1'b1);
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     dec.count = 2'd1;
                     dec.first = make_rsp(in_byte, ST_DATA, 1'b1);
                  end
               end
               MODE_ESC: begin
                  mode_in   = MODE_STR;
                  dec.count = 2'd1;
                  case (in_byte)
                     CH_QUOTE, CH_BSLASH, CH_SLASH: dec.first = make_rsp(in_byte, ST_DATA, 1'b1);
                     CH_B: dec.first = make_rsp(BYTE_BS, ST_DATA, 1'b1);
                     CH_F: dec.first = make_rsp(BYTE_FF, ST_DATA, 1'b1);
                     CH_N: dec.first = make_rsp(BYTE_LF, ST_DATA, 1'b1);
                     CH_R: dec.first = make_rsp(BYTE_CR, ST_DATA, 1'b1);
                     CH_T: dec.first = make_rsp(BYTE_TAB, ST_DATA, 1'b1);
                     CH_U: begin
                        mode_in      = MODE_HEX;
                        hex_count_in = 2'd0;
                        hex_accum_in = 12'd0;
                        dec.count    = 2'd0;
                     end
                     default: begin
                        mode_in   = MODE_IDLE;
                        dec.first = make_rsp(8'h00, ST_DECODE, 1'b1);
                     end
                  endcase
               end
               MODE_HEX: begin
                  if (!hd.ok) begin
                     mode_in   = MODE_IDLE;
                     dec.count = 2'd1;
                     dec.first = make_rsp(8'h00, ST_DECODE, 1'b1);
                  end else if (hex_count_ff != 2'd3) begin
                     hex_accum_in = code[11:0];
                     hex_count_in = hex_count_ff + 2'd1;
                  end else begin
                     hex_count_in = 2'd0;
                     hex_accum_in = 12'd0;
                     dec.count    = 2'd1;
                     if (code[15:5] == 11'd0) begin
                        mode_in   = MODE_IDLE;
                        dec.first = make_rsp(8'h00, ST_CTRL, 1'b1);
                     end else begin
                        mode_in = MODE_STR;
                        if (code[15:8] == 8'd0) begin
                           dec.first = make_rsp(code[7:0], ST_DATA, 1'b1);
                        end else begin
                           dec.count  = 2'd2;
                           dec.first  = make_rsp(code[15:8], ST_DATA, 1'b0);
                           dec.second = make_rsp(code[7:0], ST_DATA, 1'b1);
                        end
                     end
                  end
               end
               default: begin
                  mode_in = MODE_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         hex_count_ff <= 2'd0;
         hex_accum_ff <= 12'd0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
      end
   end

endmodule

// ===== hdl/jsu_result_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
// Depends on jsu_pkg for the result and decode types.
module jsu_result_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  jsu_pkg::dec_result_type dec,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output jsu_pkg::rsp_item_type   out_item
);
   import jsu_pkg::*;

   rsp_item_type           mem_ff [FifoDepth];
   logic [FifoAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]    count_ff, count_in;
   logic [FifoCntW-1:0]    n_push;
   logic                   pop;

   always_comb begin
      pop       = out_valid && out_ready;
      n_push    = push ? FifoCntW'(dec.count) : '0;
      wr_ptr_in = wr_ptr_ff + FifoAddrW'(n_push);
      rd_ptr_in = rd_ptr_ff + FifoAddrW'(pop);
      count_in  = count_ff + n_push - FifoCntW'(pop);
   end

   assign room      = count_ff <= FifoCntW'(FifoDepth - 2);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && dec.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= dec.first;
      end
      if (push && dec.count == 2'd2) begin
         mem_ff[wr_ptr_ff + FifoAddrW'(1)] <= dec.second;
      end
   end

endmodule

// ===== hdl/json_string_unescaper.sv =====
`timescale 1ns / 1ps
// JSON string unescaper top level: byte decoder feeding a four-entry result queue.
// Depends on jsu_pkg, jsu_stream_if, jsu_decode and jsu_result_fifo.
//
// Takes one raw byte per transaction, opening quote flagged by string_start, and
// returns decoded bytes, completion and error reports, one per transaction with
// last set on the final result of each input byte. A byte is decoded in the cycle
// it is accepted and its results are queued. Input throughput is one byte per
// cycle while the queue has room; a \u code above 0xFF yields two results, and
// since the output drains one result per cycle while rsp_ch.ready is high, the
// queue then limits the rate. req_ch.ready is high while the queue has room for
// two results, so input is taken while earlier results still wait on rsp_ch.
module json_string_unescaper (
   input  logic clock,
   input  logic reset,
   jsu_req_if.sink   req_ch,
   jsu_rsp_if.source rsp_ch
);
   import jsu_pkg::*;

   dec_result_type dec;
   rsp_item_type   head;
   logic           room;
   logic           fire;

   assign req_ch.ready = room;
   assign fire         = req_ch.valid && room;

   jsu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (req_ch.in_byte),
      .string_start (req_ch.string_start),
      .dec          (dec)
   );

   jsu_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .dec       (dec),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (head)
   );

   assign rsp_ch.out_byte = head.out_byte;
   assign rsp_ch.status   = head.status;
   assign rsp_ch.last     = head.last;

endmodule
